### hw/rtl/thw_pkg.sv
// Shared constants and types for the task heartbeat watchdog.
// No dependencies; used by thw_cell and task_heartbeat_watchdog.
`timescale 1ns / 1ps

package thw_pkg;

   localparam int NUM_TASKS = 8;

   localparam int REQ_TYPE_W = 2;
   localparam int TASK_ID_W  = 4;
   localparam int LIMIT_W    = 8;
   localparam int RELOAD_W   = 12;
   localparam int MASK_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [REQ_TYPE_W-1:0] REQ_CHECKIN   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SUPERVISE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_COUNTDOWN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STALL_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELOAD      = 1'd1;

   localparam logic [LIMIT_W-1:0]  STALL_LIMIT_RESET = 8'd15;
   localparam logic [RELOAD_W-1:0] RELOAD_RESET      = 12'd1000;

   typedef struct packed {
      logic               checkin;
      logic               supervise;
      logic [LIMIT_W-1:0] stall_limit;
   } cell_ctrl_type;

endpackage

### hw/rtl/thw_cell.sv
// One task slot of the watchdog chain: pending flag, seen flag, stall count.
// Depends on thw_pkg for widths and the cell control struct.
`timescale 1ns / 1ps

module thw_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  thw_pkg::cell_ctrl_type ctrl,
   input  logic                  chain_in,
   output logic                  stalled,
   output logic                  chain_out
);

   logic                         pending_ff, pending_in;
   logic                         seen_ff, seen_in;
   logic [thw_pkg::LIMIT_W-1:0]  count_ff, count_in;
   logic [thw_pkg::LIMIT_W-1:0]  count_next;

   always_comb begin
      count_next = (count_ff < ctrl.stall_limit) ? count_ff + 1'b1 : count_ff;
      stalled    = !pending_ff && seen_ff && (count_next >= ctrl.stall_limit);
      chain_out  = chain_in | stalled;
   end

   always_comb begin
      pending_in = pending_ff;
      seen_in    = seen_ff;
      count_in   = count_ff;
      if (ctrl.checkin) begin
         pending_in = 1'b1;
      end else if (ctrl.supervise) begin
         if (pending_ff) begin
            pending_in = 1'b0;
            seen_in    = 1'b1;
            count_in   = '0;
         end else if (seen_ff) begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         seen_ff    <= 1'b0;
         count_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         seen_ff    <= seen_in;
         count_ff   <= count_in;
      end
   end

endmodule

### hw/rtl/task_heartbeat_watchdog.sv
// Task heartbeat watchdog top: config registers, cell chain, countdown, result register.
// Depends on thw_pkg and thw_cell.
// A supervise or countdown beat shows its result in the cycle after acceptance.
// Throughput: one beat per cycle; a result held by rsp_stall stalls the input that cycle.
// The stalled-task chain across the cells settles within the cycle of the supervise beat.
// Reset: cells clear, countdown loads 1000, limit 15, reload 1000, no result pending.
`timescale 1ns / 1ps

module task_heartbeat_watchdog (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [thw_pkg::REQ_TYPE_W-1:0]   req_type,
   input  logic [thw_pkg::TASK_ID_W-1:0]    req_task_id,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_refresh,
   output logic [thw_pkg::MASK_W-1:0]       rsp_stalled_mask,
   output logic                             rsp_reset_request,
   input  logic                             csr_we,
   input  logic [thw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [thw_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IdW = thw_pkg::TASK_ID_W;

   logic [thw_pkg::LIMIT_W-1:0]  limit_ff, limit_in;
   logic [thw_pkg::RELOAD_W-1:0] reload_ff, reload_in;
   logic [thw_pkg::RELOAD_W-1:0] countdown_ff, countdown_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         refresh_ff, refresh_in;
   logic [thw_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic                         reset_req_ff, reset_req_in;

   logic                         accept;
   logic                         do_supervise;
   logic                         do_countdown;
   logic                         expired;
   logic [thw_pkg::NUM_TASKS-1:0] stalled_vec;
   logic [thw_pkg::NUM_TASKS:0]   chain;
   thw_pkg::cell_ctrl_type        ctrl [thw_pkg::NUM_TASKS];

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign accept       = req_valid & ~req_stall;
   assign do_supervise = accept && (req_type == thw_pkg::REQ_SUPERVISE);
   assign do_countdown = accept && (req_type == thw_pkg::REQ_COUNTDOWN);

   assign chain[0] = 1'b0;

   always_comb begin
      for (int i = 0; i < thw_pkg::NUM_TASKS; i++) begin
         ctrl[i].checkin     = accept && (req_type == thw_pkg::REQ_CHECKIN)
                               && (req_task_id == IdW'(i));
         ctrl[i].supervise   = do_supervise;
         ctrl[i].stall_limit = limit_ff;
      end
   end

   for (genvar i = 0; i < thw_pkg::NUM_TASKS; i++) begin : g_cell
      thw_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[i]),
         .chain_in  (chain[i]),
         .stalled   (stalled_vec[i]),
         .chain_out (chain[i+1])
      );
   end

   always_comb begin
      mask_in = '0;
      for (int i = 0; i < thw_pkg::NUM_TASKS; i++) begin
         mask_in[i] = stalled_vec[i];
      end
   end

   // countdown and config
   always_comb begin
      limit_in     = limit_ff;
      reload_in    = reload_ff;
      countdown_in = countdown_ff;
      expired      = 1'b0;
      if (csr_we) begin
         case (csr_index)
            thw_pkg::CSR_STALL_LIMIT: limit_in  = csr_wdata[thw_pkg::LIMIT_W-1:0];
            thw_pkg::CSR_RELOAD:      reload_in = csr_wdata[thw_pkg::RELOAD_W-1:0];
            default: ;
         endcase
      end
      if (do_supervise && !chain[thw_pkg::NUM_TASKS]) begin
         countdown_in = reload_ff;
      end else if (do_countdown) begin
         if (countdown_ff <= thw_pkg::RELOAD_W'(1)) begin
            expired      = 1'b1;
            countdown_in = reload_ff;
         end else begin
            countdown_in = countdown_ff - thw_pkg::RELOAD_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = (rsp_valid_ff & rsp_stall) | do_supervise | do_countdown;
      refresh_in   = do_supervise & ~chain[thw_pkg::NUM_TASKS];
      reset_req_in = do_countdown & expired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= thw_pkg::STALL_LIMIT_RESET;
         reload_ff    <= thw_pkg::RELOAD_RESET;
         countdown_ff <= thw_pkg::RELOAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         reload_ff    <= reload_in;
         countdown_ff <= countdown_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_supervise || do_countdown) begin
         refresh_ff   <= refresh_in;
         mask_ff      <= do_supervise ? mask_in : '0;
         reset_req_ff <= reset_req_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_refresh       = refresh_ff;
   assign rsp_stalled_mask  = mask_ff;
   assign rsp_reset_request = reset_req_ff;

   a_refresh_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(refresh_ff && reset_req_ff))
      else $error("refresh and reset request in one beat");

   a_refresh_no_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && refresh_ff) |-> (mask_ff == '0))
      else $error("refresh with stalled tasks");

   a_refresh_reload: assert property (@(posedge clock) disable iff (reset)
      (do_supervise && !chain[thw_pkg::NUM_TASKS]) |=> (countdown_ff == $past(reload_ff)))
      else $error("refresh did not reload countdown");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_countdown && countdown_ff > thw_pkg::RELOAD_W'(1)) |=>
      (countdown_ff == $past(countdown_ff) - thw_pkg::RELOAD_W'(1)) && !rsp_reset_request)
      else $error("countdown step wrong");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (do_supervise && chain[thw_pkg::NUM_TASKS]) |=> $stable(countdown_ff))
      else $error("countdown moved while a task is stalled");

endmodule

### bench/tb_task_heartbeat_watchdog.sv
// Self-checking bench for task_heartbeat_watchdog: queue-fed driver, checking monitor,
// and a per-task stall tracker that predicts every tick result. Depends on thw_pkg.
`timescale 1ns / 1ps

module tb_task_heartbeat_watchdog;

   localparam logic [thw_pkg::REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic [thw_pkg::REQ_TYPE_W-1:0] kind;
      logic [thw_pkg::TASK_ID_W-1:0]  task_id;
   } beat_type;

   typedef struct {
      logic                       refresh;
      logic [thw_pkg::MASK_W-1:0] stalled;
      logic                       reset_req;
   } tick_result_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [thw_pkg::REQ_TYPE_W-1:0] req_type;
   logic [thw_pkg::TASK_ID_W-1:0]  req_task_id;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic                           rsp_refresh;
   logic [thw_pkg::MASK_W-1:0]     rsp_stalled_mask;
   logic                           rsp_reset_request;
   logic                           csr_we;
   logic [thw_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [thw_pkg::CSR_DATA_W-1:0] csr_wdata;

   beat_type        beats_waiting[$];
   tick_result_type tick_results_due[$];

   // tracked watchdog state
   bit                           checked_in[thw_pkg::NUM_TASKS];
   bit                           ever_seen[thw_pkg::NUM_TASKS];
   logic [thw_pkg::LIMIT_W-1:0]  missed_ticks[thw_pkg::NUM_TASKS];
   logic [thw_pkg::RELOAD_W-1:0] countdown_left;
   logic [thw_pkg::LIMIT_W-1:0]  limit_cfg;
   logic [thw_pkg::RELOAD_W-1:0] reload_cfg;

   int alive_pct[thw_pkg::NUM_TASKS];
   int send_idle_pct = 35;
   int recv_idle_pct = 35;
   int error_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_req = 0;
   bit hold_done = 0;

   task_heartbeat_watchdog uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_task_id       (req_task_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_refresh       (rsp_refresh),
      .rsp_stalled_mask  (rsp_stalled_mask),
      .rsp_reset_request (rsp_reset_request),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic void advance_watchdog(input logic [thw_pkg::REQ_TYPE_W-1:0] kind,
                                            input logic [thw_pkg::TASK_ID_W-1:0] id);
      tick_result_type r;
      bit expired;
      r.refresh = 1'b0;
      r.stalled = '0;
      r.reset_req = 1'b0;
      case (kind)
         thw_pkg::REQ_CHECKIN: begin
            if (id < thw_pkg::NUM_TASKS) checked_in[id] = 1'b1;
         end
         thw_pkg::REQ_SUPERVISE: begin
            for (int i = 0; i < thw_pkg::NUM_TASKS; i++) begin
               if (checked_in[i]) begin
                  checked_in[i] = 1'b0;
                  missed_ticks[i] = '0;
                  ever_seen[i] = 1'b1;
               end else if (ever_seen[i]) begin
                  if (missed_ticks[i] < limit_cfg) missed_ticks[i] = missed_ticks[i] + 1'b1;
                  if (missed_ticks[i] >= limit_cfg) r.stalled[i] = 1'b1;
               end
            end
            if (r.stalled == '0) begin
               countdown_left = reload_cfg;
               r.refresh = 1'b1;
            end
            tick_results_due.push_back(r);
         end
         thw_pkg::REQ_COUNTDOWN: begin
            if (countdown_left == '0) begin
               expired = 1'b1;
            end else begin
               countdown_left = countdown_left - 1'b1;
               expired = (countdown_left == '0);
            end
            if (expired) countdown_left = reload_cfg;
            r.reset_req = expired;
            tick_results_due.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input int got_v, input int want_v);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got_v, want_v);
      error_count++;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) advance_watchdog(req_type, req_task_id);
         if (!req_valid || !req_stall) begin
            if (beats_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_type    <= beats_waiting[0].kind;
               req_task_id <= beats_waiting[0].task_id;
               void'(beats_waiting.pop_front());
            end else begin
               req_valid   <= 1'b0;
               req_type    <= thw_pkg::REQ_TYPE_W'($urandom_range(3));
               req_task_id <= thw_pkg::TASK_ID_W'($urandom_range(15));
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : rsp_side
      tick_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tick_results_due.size() == 0) begin
               flag_mismatch("result beat with none due", 1, 0);
            end else begin
               want = tick_results_due.pop_front();
               if (rsp_refresh !== want.refresh)
                  flag_mismatch("refresh", int'(rsp_refresh), int'(want.refresh));
               if (rsp_stalled_mask !== want.stalled)
                  flag_mismatch("stalled_mask", int'(rsp_stalled_mask), int'(want.stalled));
               if (rsp_reset_request !== want.reset_req)
                  flag_mismatch("reset_request", int'(rsp_reset_request),
                                int'(want.reset_req));
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic queue_beat(input logic [thw_pkg::REQ_TYPE_W-1:0] kind, input int id);
      beat_type b;
      b.kind = kind;
      b.task_id = id[thw_pkg::TASK_ID_W-1:0];
      beats_waiting.push_back(b);
   endtask

   // live-task check-ins, then a supervise tick; countdowns, noise; or three random beats
   task automatic queue_round(input int full_pct);
      bit full;
      full = ($urandom_range(99) < full_pct);
      if ($urandom_range(9) == 0) begin
         repeat (3) queue_beat(thw_pkg::REQ_TYPE_W'($urandom_range(3)), $urandom_range(15));
         return;
      end
      for (int i = 0; i < thw_pkg::NUM_TASKS; i++) begin
         if (full || $urandom_range(99) < alive_pct[i]) begin
            queue_beat(thw_pkg::REQ_CHECKIN, i);
            if ($urandom_range(9) == 0) queue_beat(thw_pkg::REQ_CHECKIN, i);
         end
         if ($urandom_range(9) == 0) queue_beat(thw_pkg::REQ_COUNTDOWN, $urandom_range(15));
      end
      if ($urandom_range(9) == 0)
         queue_beat(thw_pkg::REQ_CHECKIN, $urandom_range(15, thw_pkg::NUM_TASKS));
      if ($urandom_range(19) == 0) queue_beat(REQ_UNUSED, $urandom_range(15));
      queue_beat(thw_pkg::REQ_SUPERVISE, $urandom_range(15));
      repeat ($urandom_range(2)) queue_beat(thw_pkg::REQ_COUNTDOWN, $urandom_range(15));
   endtask

   task automatic write_reg(input logic [thw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [thw_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == thw_pkg::CSR_STALL_LIMIT) limit_cfg = val[thw_pkg::LIMIT_W-1:0];
      else reload_cfg = val[thw_pkg::RELOAD_W-1:0];
   endtask

   task automatic settle();
      while (beats_waiting.size() != 0 || req_valid || tick_results_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int lim_v, input int rel_v, input int full_pct,
                            input int idle_v, input int rounds, input bit with_hold);
      logic [thw_pkg::CSR_DATA_W-1:0] lim_word;
      lim_word = thw_pkg::CSR_DATA_W'($urandom);
      lim_word[thw_pkg::LIMIT_W-1:0] = thw_pkg::LIMIT_W'(lim_v);
      write_reg(thw_pkg::CSR_STALL_LIMIT, lim_word);
      write_reg(thw_pkg::CSR_RELOAD, thw_pkg::CSR_DATA_W'(rel_v));
      @(negedge clock);
      for (int i = 0; i < thw_pkg::NUM_TASKS; i++) begin
         case ($urandom_range(3))
            0: alive_pct[i] = 0;
            1: alive_pct[i] = 50;
            2: alive_pct[i] = 85;
            default: alive_pct[i] = 100;
         endcase
      end
      send_idle_pct = idle_v;
      recv_idle_pct = idle_v;
      repeat (rounds) queue_round(full_pct);
      if (with_hold) hold_req = 1'b1;
      settle();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = thw_pkg::REQ_CHECKIN;
      req_task_id = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = thw_pkg::CSR_STALL_LIMIT;
      csr_wdata = '0;
      limit_cfg = thw_pkg::STALL_LIMIT_RESET;
      reload_cfg = thw_pkg::RELOAD_RESET;
      countdown_left = thw_pkg::RELOAD_RESET;
      for (int i = 0; i < thw_pkg::NUM_TASKS; i++) begin
         checked_in[i] = 1'b0;
         ever_seen[i] = 1'b0;
         missed_ticks[i] = '0;
         alive_pct[i] = 100;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: grace period, every task, out-of-range ids, unused type, repeats
      queue_beat(thw_pkg::REQ_SUPERVISE, 0);
      queue_beat(thw_pkg::REQ_COUNTDOWN, 15);
      for (int i = 0; i < thw_pkg::NUM_TASKS; i++) queue_beat(thw_pkg::REQ_CHECKIN, i);
      queue_beat(thw_pkg::REQ_CHECKIN, 15);
      queue_beat(thw_pkg::REQ_CHECKIN, 8);
      queue_beat(REQ_UNUSED, 0);
      queue_beat(thw_pkg::REQ_CHECKIN, 0);
      queue_beat(thw_pkg::REQ_SUPERVISE, 15);
      queue_beat(thw_pkg::REQ_SUPERVISE, 0);
      queue_beat(thw_pkg::REQ_COUNTDOWN, 0);
      queue_beat(REQ_UNUSED, 15);
      settle();

      // step the default countdown down from its reset value
      repeat (40) queue_beat(thw_pkg::REQ_COUNTDOWN, $urandom_range(15));
      settle();

      run_phase(1, 3, 30, 35, 10, 1'b0);
      run_phase(0, 0, 40, 35, 10, 1'b0);
      run_phase(255, 4095, 20, 0, 10, 1'b0);
      run_phase(2, 1, 30, 35, 10, 1'b1);
      run_phase($urandom_range(6, 1), $urandom_range(15), 30, 35, 10, 1'b0);
      run_phase(3, 2, 50, 35, 10, 1'b0);
      run_phase($urandom_range(255, 1), $urandom_range(4095, 1), 30, 35, 10, 1'b0);

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
hw/rtl/thw_pkg.sv
hw/rtl/thw_cell.sv
hw/rtl/task_heartbeat_watchdog.sv
bench/tb_task_heartbeat_watchdog.sv
